// File: hw/rtl/afd_pkg.sv
// Shared types, constants and rounding helpers for the arctangent family block.
package afd_pkg;

  typedef enum logic [1:0] {
    OP_ATAN  = 2'd0,
    OP_ATAN2 = 2'd1,
    OP_ASIN  = 2'd2,
    OP_ACOS  = 2'd3
  } op_t;

  // Quadrant correction added after the core.
  typedef enum logic [1:0] {
    OFS_NONE = 2'd0,
    OFS_P180 = 2'd1,
    OFS_M180 = 2'd2
  } ofs_t;

  localparam int SQRT_STEPS = 17;
  localparam int DIV_STEPS  = 31;
  localparam int POLY_STEPS = 5;

  localparam logic [30:0] TAN15_Q30 = 31'd287708255;
  localparam logic [30:0] TAN30_Q30 = 31'd619925131;
  localparam logic signed [33:0] PI6_Q30 = 34'sd562209904;
  localparam logic signed [33:0] PI2_Q30 = 34'sd1686629713;
  localparam logic [29:0] R2D_Q24 = 30'd961263669;
  localparam logic signed [31:0] DEG90_Q22   = 32'sd377487360;
  localparam logic signed [31:0] DEG180_Q22  = 32'sd754974720;
  localparam logic signed [31:0] ANGLE_LIMIT = 32'sd759169024;

  localparam logic signed [32:0] K1 = -33'sd357913941;
  localparam logic signed [32:0] K2 = 33'sd214748361;
  localparam logic signed [32:0] K3 = -33'sd153391040;
  localparam logic signed [32:0] K4 = 33'sd119265647;
  localparam logic signed [32:0] K5 = -33'sd96544793;
  localparam logic signed [32:0] Q30_ONE = 33'sd1073741824;

  typedef struct packed {
    logic               spec;
    logic signed [31:0] spec_val;
    ofs_t               ofs;
    logic               qneg;
    logic               ovf;
    logic               neg;
    logic               recip;
    logic               shifted;
  } afd_side_t;

  // Horner coefficient added after multiply step j.
  function automatic logic signed [32:0] poly_coef(input int j);
    logic signed [32:0] c;
    unique case (j)
      0:       c = K4;
      1:       c = K3;
      2:       c = K2;
      3:       c = K1;
      default: c = Q30_ONE;
    endcase
    return c;
  endfunction

  function automatic logic [33:0] rnd_sh30(input logic [63:0] p);
    logic [63:0] s;
    s = p + (64'd1 << 29);
    return s[63:30];
  endfunction

  function automatic logic [31:0] rnd_sh32(input logic [63:0] p);
    logic [63:0] s;
    s = p + (64'd1 << 31);
    return s[63:32];
  endfunction

endpackage

// File: hw/rtl/arctangent_family_degrees.sv
// Arctangent family (atan, atan2, asin, acos) in degrees, Q16.16 in, Q9.22 out.
// Throughput: one beat per cycle; square root, three 31-stage dividers and the
// polynomial are all fully pipelined, one bit or one multiply per stage.
// A stalled output beat freezes every stage; bubbles are not squeezed out.
// Reset (rst_n low, synchronous) clears all stage valid bits; data is not reset.
module arctangent_family_degrees (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_operation,
  input  logic signed [31:0] in_arg_x,
  input  logic signed [31:0] in_arg_y,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_angle_deg
);

  logic               adv;
  logic               fr_vld;
  logic [63:0]        fr_num;
  logic [31:0]        fr_den;
  afd_pkg::afd_side_t fr_side;
  logic               dv_vld;
  logic [30:0]        dv_quo;
  afd_pkg::afd_side_t dv_side;
  logic               co_vld;
  logic signed [31:0] co_deg;
  afd_pkg::afd_side_t co_side;
  logic signed [31:0] ofs_val;
  logic               out_vld_r;
  logic signed [31:0] out_deg_r;

  // Advance everything unless the output beat is held.
  assign adv      = !(out_vld_r && out_stall);
  assign in_stall = !adv;

  afd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_vld   (in_valid),
    .in_op    (in_operation),
    .in_x     (in_arg_x),
    .in_y     (in_arg_y),
    .out_vld  (fr_vld),
    .out_num  (fr_num),
    .out_den  (fr_den),
    .out_side (fr_side)
  );

  afd_div u_div_ratio (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_vld   (fr_vld),
    .in_num   (fr_num),
    .in_den   (fr_den),
    .in_side  (fr_side),
    .out_vld  (dv_vld),
    .out_quo  (dv_quo),
    .out_side (dv_side)
  );

  afd_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_vld   (dv_vld),
    .in_quo   (dv_quo),
    .in_side  (dv_side),
    .out_vld  (co_vld),
    .out_deg  (co_deg),
    .out_side (co_side)
  );

  always_comb begin
    unique case (co_side.ofs)
      afd_pkg::OFS_NONE: ofs_val = 32'sd0;
      afd_pkg::OFS_P180: ofs_val = afd_pkg::DEG180_Q22;
      afd_pkg::OFS_M180: ofs_val = -afd_pkg::DEG180_Q22;
      default:           ofs_val = 32'sd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= co_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_deg_r <= co_side.spec ? co_side.spec_val : co_deg + ofs_val;
    end
  end

  assign out_valid     = out_vld_r;
  assign out_angle_deg = out_deg_r;

  a_no_accept_on_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |-> in_stall)
    else $error("input accepted while output beat is held");

  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_angle_deg <= afd_pkg::ANGLE_LIMIT) &&
                  (out_angle_deg >= -afd_pkg::ANGLE_LIMIT))
    else $error("angle outside +/-181 degrees");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

endmodule

// File: hw/rtl/afd_div.sv
// Pipelined restoring divider, one quotient bit per stage.
module afd_div (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  logic                in_vld,
  input  logic [63:0]         in_num,
  input  logic [31:0]         in_den,
  input  afd_pkg::afd_side_t  in_side,
  output logic                out_vld,
  output logic [30:0]         out_quo,
  output afd_pkg::afd_side_t  out_side
);

  logic               dv_vld_r  [1:afd_pkg::DIV_STEPS];
  logic [30:0]        dv_quo_r  [1:afd_pkg::DIV_STEPS];
  afd_pkg::afd_side_t dv_side_r [1:afd_pkg::DIV_STEPS];
  logic [63:0]        dv_rem_r  [1:afd_pkg::DIV_STEPS-1];
  logic [31:0]        dv_den_r  [1:afd_pkg::DIV_STEPS-1];

  for (genvar k = 0; k < afd_pkg::DIV_STEPS; k++) begin : g_step
    localparam int I = afd_pkg::DIV_STEPS - 1 - k;
    logic               cur_vld;
    logic [63:0]        cur_rem;
    logic [31:0]        cur_den;
    logic [30:0]        cur_quo;
    afd_pkg::afd_side_t cur_side;
    logic [63:0]        sub;
    logic               take;

    if (k == 0) begin : g_first
      assign cur_vld  = in_vld;
      assign cur_rem  = in_num;
      assign cur_den  = in_den;
      assign cur_quo  = '0;
      assign cur_side = in_side;
    end else begin : g_next
      assign cur_vld  = dv_vld_r[k];
      assign cur_rem  = dv_rem_r[k];
      assign cur_den  = dv_den_r[k];
      assign cur_quo  = dv_quo_r[k];
      assign cur_side = dv_side_r[k];
    end

    assign sub  = {32'd0, cur_den} << I;
    assign take = cur_rem >= sub;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_vld_r[k+1] <= 1'b0;
      end else if (adv) begin
        dv_vld_r[k+1] <= cur_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dv_quo_r[k+1]  <= take ? (cur_quo | (31'd1 << I)) : cur_quo;
        dv_side_r[k+1] <= cur_side;
      end
    end

    if (k < afd_pkg::DIV_STEPS - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (adv) begin
          dv_rem_r[k+1] <= take ? cur_rem - sub : cur_rem;
          dv_den_r[k+1] <= cur_den;
        end
      end
    end
  end

  assign out_vld  = dv_vld_r[afd_pkg::DIV_STEPS];
  assign out_quo  = dv_quo_r[afd_pkg::DIV_STEPS];
  assign out_side = dv_side_r[afd_pkg::DIV_STEPS];

endmodule

// File: hw/rtl/afd_front.sv
// Operation decode, square root pipeline and ratio setup ahead of the divider.
module afd_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  logic                in_vld,
  input  logic [1:0]          in_op,
  input  logic signed [31:0]  in_x,
  input  logic signed [31:0]  in_y,
  output logic                out_vld,
  output logic [63:0]         out_num,
  output logic [31:0]         out_den,
  output afd_pkg::afd_side_t  out_side
);

  localparam int NS = afd_pkg::SQRT_STEPS;

  logic               s0_vld_r;
  afd_pkg::op_t       s0_op_r;
  logic signed [31:0] s0_x_r;
  logic signed [31:0] s0_y_r;
  logic [31:0]        s0_ax;
  logic [33:0]        s0_sq;

  logic               s1_vld_r;
  afd_pkg::op_t       s1_op_r;
  logic signed [31:0] s1_x_r;
  logic signed [31:0] s1_y_r;
  logic [32:0]        s1_v_r;

  logic               sq_vld_r  [1:NS];
  logic [16:0]        sq_root_r [1:NS];
  afd_pkg::op_t       sq_op_r   [1:NS];
  logic signed [31:0] sq_x_r    [1:NS];
  logic signed [31:0] sq_y_r    [1:NS];
  logic [32:0]        sq_rem_r  [1:NS-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
      s1_vld_r <= 1'b0;
    end else if (adv) begin
      s0_vld_r <= in_vld;
      s1_vld_r <= s0_vld_r;
    end
  end

  assign s0_ax = s0_x_r[31] ? 32'd0 - s0_x_r : s0_x_r;
  assign s0_sq = s0_ax[16:0] * s0_ax[16:0];

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_op_r <= afd_pkg::op_t'(in_op);
      s0_x_r  <= in_x;
      s0_y_r  <= in_y;
      s1_op_r <= s0_op_r;
      s1_x_r  <= s0_x_r;
      s1_y_r  <= s0_y_r;
      // 1 - x^2 in Q32, only meaningful for |x| < 1
      s1_v_r  <= (s0_ax[31:16] == 16'd0) ? 33'h1_0000_0000 - s0_sq[32:0] : 33'd0;
    end
  end

  for (genvar k = 0; k < NS; k++) begin : g_sqrt
    localparam int B = NS - 1 - k;
    logic               cur_vld;
    logic [32:0]        cur_rem;
    logic [16:0]        cur_root;
    afd_pkg::op_t       cur_op;
    logic signed [31:0] cur_x;
    logic signed [31:0] cur_y;
    logic [34:0]        trial;
    logic               take;

    if (k == 0) begin : g_first
      assign cur_vld  = s1_vld_r;
      assign cur_rem  = s1_v_r;
      assign cur_root = '0;
      assign cur_op   = s1_op_r;
      assign cur_x    = s1_x_r;
      assign cur_y    = s1_y_r;
    end else begin : g_next
      assign cur_vld  = sq_vld_r[k];
      assign cur_rem  = sq_rem_r[k];
      assign cur_root = sq_root_r[k];
      assign cur_op   = sq_op_r[k];
      assign cur_x    = sq_x_r[k];
      assign cur_y    = sq_y_r[k];
    end

    // (r + 2^b)^2 - r^2
    assign trial = ({18'd0, cur_root} << (B + 1)) + (35'd1 << (2 * B));
    assign take  = {2'b00, cur_rem} >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_vld_r[k+1] <= 1'b0;
      end else if (adv) begin
        sq_vld_r[k+1] <= cur_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sq_root_r[k+1] <= take ? (cur_root | (17'd1 << B)) : cur_root;
        sq_op_r[k+1]   <= cur_op;
        sq_x_r[k+1]    <= cur_x;
        sq_y_r[k+1]    <= cur_y;
      end
    end

    if (k < NS - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (adv) begin
          sq_rem_r[k+1] <= take ? cur_rem - trial[32:0] : cur_rem;
        end
      end
    end
  end

  // Ratio setup
  logic signed [31:0] st_x;
  logic signed [31:0] st_y;
  logic [16:0]        st_s;
  logic [31:0]        st_ax;
  logic [31:0]        st_ay;
  logic               st_x_zero;
  logic               st_x_ge1;
  logic               st_x_lem1;
  logic [63:0]        st_num;
  logic [31:0]        st_den;
  logic               st_nneg;
  logic               st_dneg;
  afd_pkg::afd_side_t st_side;

  logic               su_vld_r;
  logic [63:0]        su_num_r;
  logic [31:0]        su_den_r;
  afd_pkg::afd_side_t su_side_r;

  logic               ov_vld_r;
  logic [63:0]        ov_num_r;
  logic [31:0]        ov_den_r;
  afd_pkg::afd_side_t ov_side_r;
  afd_pkg::afd_side_t ov_side_nxt;

  assign st_x      = sq_x_r[NS];
  assign st_y      = sq_y_r[NS];
  assign st_s      = sq_root_r[NS];
  assign st_ax     = st_x[31] ? 32'd0 - st_x : st_x;
  assign st_ay     = st_y[31] ? 32'd0 - st_y : st_y;
  assign st_x_zero = st_x == 32'sd0;
  assign st_x_ge1  = st_x >= 32'sd65536;
  assign st_x_lem1 = st_x <= -32'sd65536;

  always_comb begin
    st_num  = 64'd0;
    st_den  = 32'd1;
    st_nneg = 1'b0;
    st_dneg = 1'b0;
    st_side = '0;
    st_side.ofs = afd_pkg::OFS_NONE;
    unique case (sq_op_r[NS])
      afd_pkg::OP_ATAN: begin
        st_num  = {32'd0, st_ax};
        st_nneg = st_x[31];
      end
      afd_pkg::OP_ATAN2: begin
        if (st_x_zero) begin
          st_side.spec = 1'b1;
          if (st_y[31]) begin
            st_side.spec_val = -afd_pkg::DEG90_Q22;
          end else if (st_y == 32'sd0) begin
            st_side.spec_val = 32'sd0;
          end else begin
            st_side.spec_val = afd_pkg::DEG90_Q22;
          end
        end else begin
          st_num  = {16'd0, st_ay, 16'd0};
          st_den  = st_ax;
          st_nneg = st_y[31];
          st_dneg = st_x[31];
          if (st_x[31]) begin
            st_side.ofs = st_y[31] ? afd_pkg::OFS_M180 : afd_pkg::OFS_P180;
          end
        end
      end
      afd_pkg::OP_ASIN: begin
        priority if (st_x_ge1) begin
          st_side.spec     = 1'b1;
          st_side.spec_val = afd_pkg::DEG90_Q22;
        end else if (st_x_lem1) begin
          st_side.spec     = 1'b1;
          st_side.spec_val = -afd_pkg::DEG90_Q22;
        end else begin
          st_num  = {16'd0, st_ax, 16'd0};
          st_den  = {15'd0, st_s};
          st_nneg = st_x[31];
        end
      end
      afd_pkg::OP_ACOS: begin
        priority if (st_x_zero) begin
          st_side.spec     = 1'b1;
          st_side.spec_val = afd_pkg::DEG90_Q22;
        end else if (st_x_ge1) begin
          st_side.spec     = 1'b1;
          st_side.spec_val = 32'sd0;
        end else if (st_x_lem1) begin
          st_side.spec     = 1'b1;
          st_side.spec_val = afd_pkg::DEG180_Q22;
        end else begin
          st_num  = {31'd0, st_s, 16'd0};
          st_den  = st_ax;
          st_dneg = st_x[31];
          st_side.ofs = st_x[31] ? afd_pkg::OFS_P180 : afd_pkg::OFS_NONE;
        end
      end
    endcase
    st_side.qneg = st_nneg ^ st_dneg;
  end

  always_comb begin
    ov_side_nxt = su_side_r;
    // quotient of 2^31 or more saturates
    ov_side_nxt.ovf = su_num_r >= {1'b0, su_den_r, 31'd0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      su_vld_r <= 1'b0;
      ov_vld_r <= 1'b0;
    end else if (adv) begin
      su_vld_r <= sq_vld_r[NS];
      ov_vld_r <= su_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      su_num_r  <= st_num;
      su_den_r  <= st_den;
      su_side_r <= st_side;
      ov_num_r  <= su_num_r;
      ov_den_r  <= su_den_r;
      ov_side_r <= ov_side_nxt;
    end
  end

  assign out_vld  = ov_vld_r;
  assign out_num  = ov_num_r;
  assign out_den  = ov_den_r;
  assign out_side = ov_side_r;

endmodule

// File: hw/rtl/afd_core.sv
// Atan core: range reduction dividers, polynomial and conversion to degrees.
module afd_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  logic                in_vld,
  input  logic [30:0]         in_quo,
  input  afd_pkg::afd_side_t  in_side,
  output logic                out_vld,
  output logic signed [31:0]  out_deg,
  output afd_pkg::afd_side_t  out_side
);

  localparam int NP = afd_pkg::POLY_STEPS;

  typedef struct packed {
    logic [30:0]        x2;
    logic [30:0]        tm;
    logic               tneg;
    afd_pkg::afd_side_t side;
  } pctx_t;

  // Saturated ratio magnitude
  logic [31:0]        c0_m;
  logic               c0_vld_r;
  logic [31:0]        c0_m_r;
  afd_pkg::afd_side_t c0_side_r;
  afd_pkg::afd_side_t c0_side_nxt;

  // Reciprocal setup
  logic               c1_recip;
  logic               c1_vld_r;
  logic [63:0]        c1_num_r;
  logic [31:0]        c1_den_r;
  afd_pkg::afd_side_t c1_side_r;
  afd_pkg::afd_side_t c1_side_nxt;

  logic               d2_vld;
  logic [30:0]        d2_quo;
  afd_pkg::afd_side_t d2_side;

  logic [61:0]        c2_prod;
  logic               c2_vld_r;
  logic [30:0]        c2_t_r;
  logic [61:0]        c2_prod_r;
  afd_pkg::afd_side_t c2_side_r;
  afd_pkg::afd_side_t c2_side_nxt;

  logic [33:0]        c3_rnd;
  logic signed [31:0] c3_dif;
  logic [31:0]        c3_dmag;
  logic               c3_vld_r;
  logic [63:0]        c3_num_r;
  logic [31:0]        c3_den_r;
  afd_pkg::afd_side_t c3_side_r;
  afd_pkg::afd_side_t c3_side_nxt;

  logic               d3_vld;
  logic [30:0]        d3_quo;
  afd_pkg::afd_side_t d3_side;

  logic [61:0]        c4_prod;
  logic               c4_vld_r;
  logic [61:0]        c4_prod_r;
  logic [30:0]        c4_tm_r;
  logic               c4_tneg_r;
  afd_pkg::afd_side_t c4_side_r;

  logic [33:0]        c5_rnd;
  logic               c5_vld_r;
  pctx_t              c5_ctx_r;

  logic               pm_vld_r  [0:NP-1];
  logic [63:0]        pm_prod_r [0:NP-1];
  logic               pm_sgn_r  [0:NP-1];
  pctx_t              pm_ctx_r  [0:NP-1];
  logic               pa_vld_r  [0:NP-1];
  logic signed [32:0] pa_p_r    [0:NP-1];
  pctx_t              pa_ctx_r  [0:NP-1];

  logic signed [32:0] rm_p;
  logic [32:0]        rm_pmag;
  logic [63:0]        rm_prod;
  logic               rm_vld_r;
  logic [63:0]        rm_prod_r;
  logic               rm_sgn_r;
  afd_pkg::afd_side_t rm_side_r;

  logic [33:0]        r1_rnd;
  logic signed [33:0] r1_val;
  logic               r1_vld_r;
  logic signed [33:0] r1_r;
  afd_pkg::afd_side_t r1_side_r;

  logic signed [33:0] r2_a;
  logic signed [33:0] r2_b;
  logic               r2_vld_r;
  logic signed [33:0] r2_r;
  afd_pkg::afd_side_t r2_side_r;

  logic [33:0]        dm_mag;
  logic [63:0]        dm_prod;
  logic               dm_vld_r;
  logic [63:0]        dm_prod_r;
  logic               dm_sgn_r;
  afd_pkg::afd_side_t dm_side_r;

  logic [31:0]        d1_rnd;
  logic               d1_vld_r;
  logic signed [31:0] d1_deg_r;
  afd_pkg::afd_side_t d1_side_r;

  assign c0_m = in_side.ovf ? (in_side.qneg ? 32'h8000_0000 : 32'h7FFF_FFFF)
                            : {1'b0, in_quo};
  assign c1_recip = c0_m_r > 32'd65536;

  // Small arguments pass through the divider with a unit divisor.
  afd_div u_div_recip (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_vld   (c1_vld_r),
    .in_num   (c1_num_r),
    .in_den   (c1_den_r),
    .in_side  (c1_side_r),
    .out_vld  (d2_vld),
    .out_quo  (d2_quo),
    .out_side (d2_side)
  );

  assign c2_prod = afd_pkg::TAN30_Q30 * d2_quo;

  assign c3_rnd  = afd_pkg::rnd_sh30({2'b00, c2_prod_r});
  assign c3_dif  = $signed({1'b0, c2_t_r}) - $signed({1'b0, afd_pkg::TAN30_Q30});
  assign c3_dmag = c3_dif[31] ? 32'd0 - c3_dif : c3_dif;

  // Unshifted values pass through with divisor 1.0 in Q30.
  afd_div u_div_shift (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_vld   (c3_vld_r),
    .in_num   (c3_num_r),
    .in_den   (c3_den_r),
    .in_side  (c3_side_r),
    .out_vld  (d3_vld),
    .out_quo  (d3_quo),
    .out_side (d3_side)
  );

  assign c4_prod = d3_quo * d3_quo;
  assign c5_rnd  = afd_pkg::rnd_sh30({2'b00, c4_prod_r});

  always_comb begin
    c0_side_nxt         = in_side;
    c0_side_nxt.neg     = in_side.qneg;
    c1_side_nxt         = c0_side_r;
    c1_side_nxt.recip   = c1_recip;
    c2_side_nxt         = d2_side;
    c2_side_nxt.shifted = d2_quo > afd_pkg::TAN15_Q30;
    c3_side_nxt         = c2_side_r;
    c3_side_nxt.qneg    = c2_side_r.shifted ? c3_dif[31] : 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c0_vld_r <= 1'b0;
      c1_vld_r <= 1'b0;
      c2_vld_r <= 1'b0;
      c3_vld_r <= 1'b0;
      c4_vld_r <= 1'b0;
      c5_vld_r <= 1'b0;
    end else if (adv) begin
      c0_vld_r <= in_vld;
      c1_vld_r <= c0_vld_r;
      c2_vld_r <= d2_vld;
      c3_vld_r <= c2_vld_r;
      c4_vld_r <= d3_vld;
      c5_vld_r <= c4_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c0_m_r    <= c0_m;
      c0_side_r <= c0_side_nxt;

      c1_num_r  <= c1_recip ? (64'd1 << 46) + {33'd0, c0_m_r[31:1]}
                            : {18'd0, c0_m_r, 14'd0};
      c1_den_r  <= c1_recip ? c0_m_r : 32'd1;
      c1_side_r <= c1_side_nxt;

      c2_t_r    <= d2_quo;
      c2_prod_r <= c2_prod;
      c2_side_r <= c2_side_nxt;

      c3_side_r <= c3_side_nxt;
      if (c2_side_r.shifted) begin
        c3_num_r <= {3'd0, c3_dmag[30:0], 30'd0};
        c3_den_r <= 32'h4000_0000 + c3_rnd[31:0];
      end else begin
        c3_num_r <= {3'd0, c2_t_r, 30'd0};
        c3_den_r <= 32'h4000_0000;
      end

      c4_prod_r <= c4_prod;
      c4_tm_r   <= d3_quo;
      c4_tneg_r <= d3_side.qneg;
      c4_side_r <= d3_side;

      c5_ctx_r.x2   <= c5_rnd[30:0];
      c5_ctx_r.tm   <= c4_tm_r;
      c5_ctx_r.tneg <= c4_tneg_r;
      c5_ctx_r.side <= c4_side_r;
    end
  end

  // Horner steps: multiply stage, then round and add stage.
  for (genvar j = 0; j < NP; j++) begin : g_poly
    localparam logic signed [32:0] COEF = afd_pkg::poly_coef(j);
    logic               cur_vld;
    logic signed [32:0] cur_p;
    pctx_t              cur_ctx;
    logic [32:0]        pmag;
    logic [33:0]        rnd;
    logic signed [33:0] term;
    logic signed [33:0] sum;

    if (j == 0) begin : g_first
      assign cur_vld = c5_vld_r;
      assign cur_p   = afd_pkg::K5;
      assign cur_ctx = c5_ctx_r;
    end else begin : g_next
      assign cur_vld = pa_vld_r[j-1];
      assign cur_p   = pa_p_r[j-1];
      assign cur_ctx = pa_ctx_r[j-1];
    end

    assign pmag = cur_p[32] ? 33'd0 - cur_p : cur_p;
    assign rnd  = afd_pkg::rnd_sh30(pm_prod_r[j]);
    assign term = pm_sgn_r[j] ? -$signed(rnd) : $signed(rnd);
    assign sum  = 34'(COEF) + term;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        pm_vld_r[j] <= 1'b0;
        pa_vld_r[j] <= 1'b0;
      end else if (adv) begin
        pm_vld_r[j] <= cur_vld;
        pa_vld_r[j] <= pm_vld_r[j];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        pm_prod_r[j] <= cur_ctx.x2 * pmag[31:0];
        pm_sgn_r[j]  <= cur_p[32];
        pm_ctx_r[j]  <= cur_ctx;
        pa_p_r[j]    <= sum[32:0];
        pa_ctx_r[j]  <= pm_ctx_r[j];
      end
    end
  end

  assign rm_p    = pa_p_r[NP-1];
  assign rm_pmag = rm_p[32] ? 33'd0 - rm_p : rm_p;
  assign rm_prod = pa_ctx_r[NP-1].tm * rm_pmag[31:0];

  assign r1_rnd = afd_pkg::rnd_sh30(rm_prod_r);
  assign r1_val = rm_sgn_r ? -$signed(r1_rnd) : $signed(r1_rnd);

  assign r2_a = r1_side_r.recip ? afd_pkg::PI2_Q30 - r1_r : r1_r;
  assign r2_b = r1_side_r.neg ? -r2_a : r2_a;

  assign dm_mag  = r2_r[33] ? 34'd0 - r2_r : r2_r;
  assign dm_prod = dm_mag[31:0] * afd_pkg::R2D_Q24;

  assign d1_rnd = afd_pkg::rnd_sh32(dm_prod_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rm_vld_r <= 1'b0;
      r1_vld_r <= 1'b0;
      r2_vld_r <= 1'b0;
      dm_vld_r <= 1'b0;
      d1_vld_r <= 1'b0;
    end else if (adv) begin
      rm_vld_r <= pa_vld_r[NP-1];
      r1_vld_r <= rm_vld_r;
      r2_vld_r <= r1_vld_r;
      dm_vld_r <= r2_vld_r;
      d1_vld_r <= dm_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rm_prod_r <= rm_prod;
      rm_sgn_r  <= pa_ctx_r[NP-1].tneg ^ rm_p[32];
      rm_side_r <= pa_ctx_r[NP-1].side;

      r1_r      <= rm_side_r.shifted ? r1_val + afd_pkg::PI6_Q30 : r1_val;
      r1_side_r <= rm_side_r;

      r2_r      <= r2_b;
      r2_side_r <= r1_side_r;

      dm_prod_r <= dm_prod;
      dm_sgn_r  <= r2_r[33];
      dm_side_r <= r2_side_r;

      d1_deg_r  <= dm_sgn_r ? -$signed(d1_rnd) : $signed(d1_rnd);
      d1_side_r <= dm_side_r;
    end
  end

  assign out_vld  = d1_vld_r;
  assign out_deg  = d1_deg_r;
  assign out_side = d1_side_r;

endmodule
